@@ rtl/radlk_pkg.sv @@
`default_nettype none

package radlk_pkg;

  // link protocol codes
  localparam logic [7:0] CODE_SOH     = 8'h01;
  localparam logic [7:0] CODE_ACK     = 8'h06;
  localparam logic [7:0] CODE_NOMATCH = 8'hFF;
  localparam logic [7:0] PRINT_LO     = 8'h20;
  localparam logic [7:0] PRINT_HI     = 8'h7F;

  // counter geometry
  localparam int unsigned CNT_W = 12;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_EXTRA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TMO    = 2'd2;

  // configuration reset values
  localparam logic [9:0]  BACKOFF_RST    = 10'd100;
  localparam logic [10:0] IDLE_EXTRA_RST = 11'd1000;
  localparam logic [9:0]  ACK_TMO_RST    = 10'd500;

  typedef enum logic [2:0] {
    ST_CONNECT  = 3'd0,
    ST_IDLE     = 3'd1,
    ST_SEND     = 3'd2,
    ST_RECEIVE  = 3'd3,
    ST_AWAIT    = 3'd4,
    ST_SEND_ACK = 3'd5
  } link_state_e;

  typedef struct packed {
    logic [9:0]  backoff_ticks;
    logic [10:0] idle_extra_ticks;
    logic [9:0]  ack_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        carrier_detect;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        uart_valid;
    logic [31:0] uart_addr;
    logic [7:0]  uart_data;
  } in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [31:0] tx_addr;
    logic [7:0]  tx_byte;
    logic        uart_out_valid;
    logic [7:0]  uart_out_byte;
    logic        uart_taken;
    logic        link_up;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/radlk_cfg.sv @@
`default_nettype none

module radlk_cfg
  import radlk_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BACKOFF:    cfg_d.backoff_ticks     = cfg_data_i[9:0];
        CFG_IDLE_EXTRA: cfg_d.idle_extra_ticks  = cfg_data_i;
        CFG_ACK_TMO:    cfg_d.ack_timeout_ticks = cfg_data_i[9:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backoff_ticks     <= BACKOFF_RST;
      cfg_q.idle_extra_ticks  <= IDLE_EXTRA_RST;
      cfg_q.ack_timeout_ticks <= ACK_TMO_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/radlk_fsm.sv @@
`default_nettype none

module radlk_fsm
  import radlk_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  in_t       item_i,
  input  cfg_t      cfg_i,
  output out_t      res_o
);

  link_state_e      state_q, state_d;
  logic [CNT_W-1:0] conn_cnt_q, conn_cnt_d;
  logic [CNT_W-1:0] idle_cnt_q, idle_cnt_d;
  logic [CNT_W-1:0] ack_cnt_q, ack_cnt_d;
  logic [CNT_W-1:0] ack_cnt_inc;
  logic [CNT_W-1:0] idle_limit;
  logic [7:0]       last_rx_q, last_rx_d;
  logic [31:0]      dest_addr_q, dest_addr_d;
  logic [7:0]       pend_data_q, pend_data_d;
  logic             link_q, link_d;
  logic             rx_hit;
  logic             tx_valid;
  logic [7:0]       tx_byte;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // a polled frame counts only when the address matched
  assign rx_hit      = item_i.rx_ready && (item_i.rx_byte != CODE_NOMATCH);
  assign ack_cnt_inc = sat_inc(ack_cnt_q);
  assign idle_limit  = CNT_W'(cfg_i.backoff_ticks) + CNT_W'(cfg_i.idle_extra_ticks);

  // next state and result of one tick
  always_comb begin
    state_d     = state_q;
    conn_cnt_d  = conn_cnt_q;
    idle_cnt_d  = idle_cnt_q;
    ack_cnt_d   = ack_cnt_q;
    last_rx_d   = last_rx_q;
    dest_addr_d = dest_addr_q;
    pend_data_d = pend_data_q;
    link_d      = link_q;
    tx_valid    = 1'b0;
    tx_byte     = '0;
    res_o       = '0;

    unique case (state_q)
      ST_CONNECT: begin
        if ((conn_cnt_q > CNT_W'(cfg_i.backoff_ticks)) && !item_i.carrier_detect) begin
          conn_cnt_d = '0;
          tx_valid   = 1'b1;
          tx_byte    = CODE_SOH;
        end else begin
          conn_cnt_d = sat_inc(conn_cnt_q);
          if (item_i.rx_ready) begin
            last_rx_d = item_i.rx_byte;
          end
          if (item_i.rx_ready && item_i.rx_byte == CODE_ACK) begin
            link_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (item_i.rx_ready && item_i.rx_byte == CODE_SOH) begin
            tx_valid = 1'b1;
            tx_byte  = CODE_ACK;
            link_d   = 1'b1;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (item_i.uart_valid) begin
          dest_addr_d      = item_i.uart_addr;
          pend_data_d      = item_i.uart_data;
          res_o.uart_taken = 1'b1;
          idle_cnt_d       = '0;
          state_d          = ST_SEND;
        end else begin
          if (item_i.rx_ready) begin
            last_rx_d = item_i.rx_byte;
          end
          if (rx_hit) begin
            idle_cnt_d = '0;
            state_d    = ST_RECEIVE;
          end else if (idle_cnt_q > idle_limit) begin
            idle_cnt_d = '0;
            tx_valid   = 1'b1;
            tx_byte    = CODE_SOH;
            state_d    = ST_AWAIT;
          end else begin
            idle_cnt_d = sat_inc(idle_cnt_q);
          end
        end
      end
      ST_SEND: begin
        if (!item_i.carrier_detect) begin
          tx_valid = 1'b1;
          tx_byte  = pend_data_q;
          state_d  = ST_AWAIT;
        end
      end
      ST_RECEIVE: begin
        if (last_rx_q >= PRINT_LO && last_rx_q <= PRINT_HI) begin
          res_o.uart_out_valid = 1'b1;
          res_o.uart_out_byte  = last_rx_q;
          state_d              = ST_SEND_ACK;
        end else if (last_rx_q == CODE_SOH) begin
          state_d = ST_SEND_ACK;
        end else begin
          state_d = ST_CONNECT;
          link_d  = 1'b0;
        end
      end
      ST_AWAIT: begin
        if (item_i.rx_ready) begin
          last_rx_d = item_i.rx_byte;
        end
        if (rx_hit) begin
          ack_cnt_d = '0;
          if (item_i.rx_byte == CODE_ACK) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_CONNECT;
            link_d  = 1'b0;
          end
        end else if (ack_cnt_inc > CNT_W'(cfg_i.ack_timeout_ticks)) begin
          ack_cnt_d = '0;
          state_d   = ST_CONNECT;
          link_d    = 1'b0;
        end else begin
          ack_cnt_d = ack_cnt_inc;
        end
      end
      ST_SEND_ACK: begin
        tx_valid = 1'b1;
        tx_byte  = CODE_ACK;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_CONNECT;
      end
    endcase

    // frame fields read zero when nothing is sent
    res_o.tx_valid = tx_valid;
    res_o.tx_addr  = tx_valid ? dest_addr_q : '0;
    res_o.tx_byte  = tx_byte;
    res_o.link_up  = link_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CONNECT;
      conn_cnt_q  <= '0;
      idle_cnt_q  <= '0;
      ack_cnt_q   <= '0;
      last_rx_q   <= '0;
      dest_addr_q <= '0;
      pend_data_q <= '0;
      link_q      <= 1'b0;
    end else if (step_i) begin
      state_q     <= state_d;
      conn_cnt_q  <= conn_cnt_d;
      idle_cnt_q  <= idle_cnt_d;
      ack_cnt_q   <= ack_cnt_d;
      last_rx_q   <= last_rx_d;
      dest_addr_q <= dest_addr_d;
      pend_data_q <= pend_data_d;
      link_q      <= link_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/radlk_outbuf.sv @@
`default_nettype none

module radlk_outbuf
  import radlk_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  out_t      push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic main_vld_q, main_vld_d;
  logic skid_vld_q, skid_vld_d;
  out_t main_q, main_d;
  out_t skid_q, skid_d;
  logic pop;

  assign pop = main_vld_q && !out_stall_i;

  // two-entry buffer: main drives the port, skid catches a request under stall
  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else if (push_i) begin
        main_d = push_data_i;
      end else begin
        main_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (main_vld_q) begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end else begin
        main_d     = push_data_i;
        main_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

endmodule

`default_nettype wire

@@ rtl/radio_link_handshake_fsm_unit.sv @@
`default_nettype none

// channel   direction  handshake             payload
// in        input      in_valid_i/in_stall_o    in_data_i   (in_t)
// out       output     out_valid_o/out_stall_i  out_data_o  (out_t)
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// one tick per cycle while in_stall_o is low: an accepted tick updates the link
// state machine in its accept cycle and its result is registered before it is
// on out_data_o; it passes through a two-entry output buffer, so a tick is still
// taken while one result waits; in_stall_o rises only when both entries hold
// reset puts the link in connect request with all counters and latches cleared
// and the three timing registers at their default values

module radio_link_handshake_fsm_unit
  import radlk_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  in_t                        in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_t                       out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;
  out_t res;
  logic step;
  logic buf_full;

  assign in_stall_o = buf_full;
  assign step       = in_valid_i && !buf_full;

  // timing registers
  radlk_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // link state machine
  radlk_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result buffer
  radlk_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/radlk_checker.sv @@
`default_nettype none

module radlk_checker
  import radlk_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input out_t      out_data_o
);

  // a result appears only after a request was taken
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without an accepted request");

  // frame fields are zero when no frame is sent
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tx_valid |->
      out_data_o.tx_addr == '0 && out_data_o.tx_byte == '0)
    else $error("frame fields set without a frame");

  // forwarded bytes are printable and never share a tick with a frame
  a_uart_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.uart_out_valid |->
      out_data_o.uart_out_byte >= PRINT_LO && out_data_o.uart_out_byte <= PRINT_HI &&
      !out_data_o.tx_valid)
    else $error("bad forwarded byte");

  // messages are only taken while the link is up
  a_taken_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.uart_taken |-> out_data_o.link_up && !out_data_o.tx_valid)
    else $error("message taken without link");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind radio_link_handshake_fsm_unit radlk_checker u_radlk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
